// File: src/qbim_pkg.sv
package qbim_pkg;

  localparam int MAX_DEPTH_DEF  = 16;
  localparam int NODE_COUNT_DEF = 4096;

  localparam int DEPTH_W = 5;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;

  localparam logic [DEPTH_W-1:0] TREE_DEPTH_RST = 5'd16;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_SET    = 1'b1;

  // node store strobes for one cycle
  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic leaf_we;
  } node_ctl_t;

endpackage

// File: src/qbim_if.sv
interface qbim_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [qbim_pkg::KEY_W-1:0]   key;
  logic [qbim_pkg::VALUE_W-1:0] new_value;

  modport source (output valid, output kind, output key, output new_value, input ready);
  modport sink   (input valid, input kind, input key, input new_value, output ready);
endinterface

interface qbim_out_if;
  logic                        valid;
  logic                        ready;
  logic [qbim_pkg::VALUE_W-1:0] value;
  logic                        absent;
  logic                        pool_full;

  modport source (output valid, output value, output absent, output pool_full, input ready);
  modport sink   (input valid, input value, input absent, input pool_full, output ready);
endinterface

// File: src/qbim_node_store.sv
module qbim_node_store #(
  parameter int NODE_COUNT = qbim_pkg::NODE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  qbim_pkg::node_ctl_t                ctl,
  input  logic [$clog2(NODE_COUNT)-1:0]      rd_addr,
  input  logic [$clog2(NODE_COUNT)-1:0]      link_waddr,
  input  logic [4*$clog2(NODE_COUNT)-1:0]    link_wdata,
  input  logic [$clog2(NODE_COUNT)-1:0]      leaf_waddr,
  input  logic [qbim_pkg::VALUE_W-1:0]       leaf_wdata,
  output logic [4*$clog2(NODE_COUNT)-1:0]    link_rdata,
  output logic [qbim_pkg::VALUE_W-1:0]       leaf_rdata
);
  import qbim_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int WORD_W = 4 * NODE_W;

  logic [WORD_W-1:0]  link_mem [NODE_COUNT];
  logic [VALUE_W-1:0] leaf_mem [NODE_COUNT];

  logic [WORD_W-1:0]  link_q;
  logic [VALUE_W-1:0] leaf_q;

  // root is the only entry that can be read before it is written
  logic root_link_ok;
  logic root_leaf_ok;
  logic link_blank;
  logic leaf_blank;

  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ctl.leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    if (ctl.rd_en) begin
      link_q <= link_mem[rd_addr];
      leaf_q <= leaf_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_link_ok <= 1'b0;
      root_leaf_ok <= 1'b0;
      link_blank   <= 1'b0;
      leaf_blank   <= 1'b0;
    end else begin
      if (ctl.link_we && link_waddr == '0) begin
        root_link_ok <= 1'b1;
      end
      if (ctl.leaf_we && leaf_waddr == '0) begin
        root_leaf_ok <= 1'b1;
      end
      if (ctl.rd_en) begin
        link_blank <= (rd_addr == '0) && !root_link_ok;
        leaf_blank <= (rd_addr == '0) && !root_leaf_ok;
      end
    end
  end

  assign link_rdata = link_blank ? '0 : link_q;
  assign leaf_rdata = leaf_blank ? '0 : leaf_q;

endmodule

// File: src/quadtree_block_index_map_unit.sv
// channel  | dir | transaction payload
// ---------+-----+-------------------------------------------
// req      | in  | kind (0 lookup, 1 set), key, new_value
// rsp      | out | value, absent, pool_full
// cfg      | in  | cfg_we / cfg_wdata -> tree_depth
//
// one item at a time; a lookup hit walks every level from the root, then shows rsp valid;
// a missing link or a refused set ends sooner, where the walk stops
// an accepted set walks the present links, then each new node takes the place of one walk read,
// plus a leaf write in ST_FIN; req is ready again the cycle after rsp is loaded
// the walk is paced by the node store read port: one node read per tree level
// rst clears control, sets the pool count to one (root only); no clearing pass,
// the pool count and two root flags stand in for the cleared node store
// a stalled rsp holds its result; a new req is taken while a result still waits
module quadtree_block_index_map_unit #(
  parameter int MAX_DEPTH  = qbim_pkg::MAX_DEPTH_DEF,
  parameter int NODE_COUNT = qbim_pkg::NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [qbim_pkg::DEPTH_W-1:0]  cfg_wdata,
  qbim_in_if.sink                       req,
  qbim_out_if.source                    rsp
);
  import qbim_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int WORD_W = 4 * NODE_W;
  localparam int STEP_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int USED_W = $clog2(NODE_COUNT + 1);
  localparam int SUM_W  = USED_W + STEP_W;
  localparam int WIDE_W = 2 * KEY_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t               state;
  logic [DEPTH_W-1:0]   tree_depth;
  logic                 kind;
  logic [VALUE_W-1:0]   new_value;
  logic [MAX_DEPTH-1:0] row;
  logic [MAX_DEPTH-1:0] col;
  logic [NODE_W-1:0]    cur;
  logic [STEP_W-1:0]    step;
  logic [WORD_W-1:0]    word;
  logic [USED_W-1:0]    nodes_used;
  logic                 grew;
  logic [VALUE_W-1:0]   res_value;
  logic                 res_absent;
  logic                 res_full;
  logic                 out_valid;
  logic [VALUE_W-1:0]   out_value;
  logic                 out_absent;
  logic                 out_full;

  // node store port
  node_ctl_t            ctl;
  logic [NODE_W-1:0]    rd_addr;
  logic [NODE_W-1:0]    link_waddr;
  logic [WORD_W-1:0]    link_wdata;
  logic [NODE_W-1:0]    leaf_waddr;
  logic [VALUE_W-1:0]   leaf_wdata;
  logic [WORD_W-1:0]    link_rdata;
  logic [VALUE_W-1:0]   leaf_rdata;

  logic                 req_fire;
  logic                 out_load;
  logic [STEP_W-1:0]    depth_eff;
  logic [WIDE_W-1:0]    key_wide;
  logic [IDX_W-1:0]     bit_idx;
  logic [1:0]           slot;
  logic [NODE_W-1:0]    link_sel;
  logic [WORD_W-1:0]    word_mod;
  logic                 pool_short;

  assign req_fire = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  // finished result moves to the output register once it is free
  assign out_load = (state == ST_DONE) && (!out_valid || rsp.ready);

  // depth register above the tree height acts as the full height
  assign depth_eff = ({1'b0, tree_depth} > (DEPTH_W + 1)'(MAX_DEPTH)) ?
                     STEP_W'(MAX_DEPTH) : STEP_W'(tree_depth);
  assign key_wide  = {{KEY_W{1'b0}}, req.key};

  // child slot at this level: row bit over column bit, msb first
  assign bit_idx  = IDX_W'(step - STEP_W'(1));
  assign slot     = {row[bit_idx], col[bit_idx]};
  assign link_sel = link_rdata[int'(slot)*NODE_W +: NODE_W];

  // current node word with the walked slot pointing at the next free node
  always_comb begin
    word_mod = word;
    word_mod[int'(slot)*NODE_W +: NODE_W] = nodes_used[NODE_W-1:0];
  end

  assign pool_short = (SUM_W'(nodes_used) + SUM_W'(step)) > SUM_W'(NODE_COUNT);

  // node store access per state
  always_comb begin
    ctl        = '0;
    rd_addr    = link_sel;
    link_waddr = cur;
    link_wdata = '0;
    leaf_waddr = cur;
    leaf_wdata = '0;
    case (state)
      ST_IDLE: begin
        ctl.rd_en = req_fire;
        rd_addr   = '0;
      end
      ST_WALK: begin
        // next level read issued straight from the returning link
        ctl.rd_en = (step != '0) && (link_sel != '0);
      end
      ST_ALLOC: begin
        ctl.link_we = 1'b1;
        link_wdata  = word_mod;
        ctl.leaf_we = 1'b1;
        leaf_waddr  = nodes_used[NODE_W-1:0];
      end
      ST_FIN: begin
        // a newly taken leaf node also gets its links cleared
        ctl.link_we = grew;
        ctl.leaf_we = 1'b1;
        leaf_wdata  = new_value;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tree_depth <= TREE_DEPTH_RST;
      nodes_used <= USED_W'(1);
      out_valid  <= 1'b0;
      grew       <= 1'b0;
    end else begin
      if (cfg_we) begin
        tree_depth <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            kind      <= req.kind;
            new_value <= req.new_value;
            row       <= MAX_DEPTH'(key_wide >> depth_eff);
            col       <= key_wide[MAX_DEPTH-1:0];
            step      <= depth_eff;
            cur       <= '0;
            grew      <= 1'b0;
            state     <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (step == '0) begin
            // full path present, leaf data arrived with the last node read
            res_absent <= 1'b0;
            res_full   <= 1'b0;
            if (kind == KIND_LOOKUP) begin
              res_value <= leaf_rdata;
              state     <= ST_DONE;
            end else begin
              state <= ST_FIN;
            end
          end else if (link_sel != '0) begin
            cur  <= link_sel;
            step <= step - STEP_W'(1);
          end else if (kind == KIND_LOOKUP) begin
            res_value  <= '0;
            res_absent <= 1'b1;
            res_full   <= 1'b0;
            state      <= ST_DONE;
          end else if (pool_short) begin
            res_value  <= '0;
            res_absent <= 1'b0;
            res_full   <= 1'b1;
            state      <= ST_DONE;
          end else begin
            word  <= link_rdata;
            state <= ST_ALLOC;
          end
        end
        ST_ALLOC: begin
          cur        <= nodes_used[NODE_W-1:0];
          word       <= '0;
          nodes_used <= nodes_used + USED_W'(1);
          step       <= step - STEP_W'(1);
          grew       <= 1'b1;
          if (step == STEP_W'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          res_value  <= new_value;
          res_absent <= 1'b0;
          res_full   <= 1'b0;
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_value  <= res_value;
            out_absent <= res_absent;
            out_full   <= res_full;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.value     = out_value;
  assign rsp.absent    = out_absent;
  assign rsp.pool_full = out_full;

  qbim_node_store #(
    .NODE_COUNT (NODE_COUNT)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .leaf_waddr (leaf_waddr),
    .leaf_wdata (leaf_wdata),
    .link_rdata (link_rdata),
    .leaf_rdata (leaf_rdata)
  );

`ifndef SYNTHESIS
  // node allocation only happens with a free node left in the pool
  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC) |-> (nodes_used < USED_W'(NODE_COUNT)) && (step != '0))
    else $error("node taken from an empty pool");

  // the pool count moves only while nodes are being taken
  a_pool_steady: assert property (@(posedge clk)
    (!rst && state != ST_ALLOC) |=> $stable(nodes_used))
    else $error("pool count changed outside allocation");

  // a result never reports a missing link and a refused set at once
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.absent && rsp.pool_full))
    else $error("absent and pool_full both set");
`endif

endmodule

// File: sim/qbim_checker.sv
`timescale 1ns / 1ps

// watches both channels, keeps its own copy of the node pool and flags any
// response that disagrees with it
module qbim_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [qbim_pkg::DEPTH_W-1:0] cfg_wdata,
  qbim_in_if                           req,
  qbim_out_if                          rsp,
  output int                           outstanding,
  output int                           mismatches
);
  import qbim_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT_DEF);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               absent;
    logic               pool_full;
  } map_result_t;

  bit [NODE_W-1:0]  child_link [NODE_COUNT_DEF][4];
  bit [VALUE_W-1:0] leaf_value [NODE_COUNT_DEF];
  bit [NODE_W:0]    nodes_taken;
  bit [DEPTH_W-1:0] depth_reg;
  map_result_t      expected_q [$];
  int               errors = 0;

  // walk the tree for one request, grow it on a set, return the response
  function automatic map_result_t map_access(input logic kind, input logic [KEY_W-1:0] key,
                                             input logic [VALUE_W-1:0] wr_value);
    int unsigned      levels;
    int unsigned      lvl;
    int               s;
    logic [KEY_W-1:0] span;
    logic [KEY_W-1:0] row;
    logic [KEY_W-1:0] col;
    bit [NODE_W-1:0]  cur;
    bit [NODE_W-1:0]  nxt;
    bit               walking;
    map_result_t      res;
    levels = (depth_reg > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : depth_reg;
    span = (32'd1 << levels) - 32'd1;
    row = (key >> levels) & span;
    col = key & span;
    cur = '0;
    lvl = levels;
    res = '0;
    walking = 1'b1;
    while (walking && lvl > 0) begin
      nxt = child_link[cur][{row[lvl-1], col[lvl-1]}];
      if (nxt == '0) begin
        walking = 1'b0;
      end else begin
        cur = nxt;
        lvl--;
      end
    end
    if (kind == KIND_LOOKUP) begin
      if (lvl > 0) res.absent = 1'b1;
      else res.value = leaf_value[cur];
    end else if (nodes_taken + lvl > NODE_COUNT_DEF) begin
      res.pool_full = 1'b1;
    end else begin
      // lvl is the number of fresh nodes this set needs
      while (lvl > 0) begin
        lvl--;
        nxt = nodes_taken[NODE_W-1:0];
        nodes_taken++;
        for (s = 0; s < 4; s++) child_link[nxt][s] = '0;
        leaf_value[nxt] = '0;
        child_link[cur][{row[lvl], col[lvl]}] = nxt;
        cur = nxt;
      end
      leaf_value[cur] = wr_value;
      res.value = wr_value;
    end
    return res;
  endfunction

  always @(posedge clk) begin : track
    map_result_t got;
    map_result_t want;
    int          n;
    int          s;
    if (rst) begin
      for (n = 0; n < NODE_COUNT_DEF; n++) begin
        for (s = 0; s < 4; s++) child_link[n][s] = '0;
        leaf_value[n] = '0;
      end
      nodes_taken = 1;
      depth_reg = TREE_DEPTH_RST;
      expected_q.delete();
    end else begin
      if (cfg_we) depth_reg = cfg_wdata;
      if (req.valid && req.ready)
        expected_q.push_back(map_access(req.kind, req.key, req.new_value));
      if (rsp.valid && rsp.ready) begin
        got.value = rsp.value;
        got.absent = rsp.absent;
        got.pool_full = rsp.pool_full;
        if (expected_q.size() == 0) begin
          $error("unexpected rsp transaction: value %h absent %b pool_full %b",
                 got.value, got.absent, got.pool_full);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value) begin
            $error("value mismatch: expected %h, actual %h", want.value, got.value);
            errors++;
          end
          if (got.absent !== want.absent) begin
            $error("absent mismatch: expected %b, actual %b", want.absent, got.absent);
            errors++;
          end
          if (got.pool_full !== want.pool_full) begin
            $error("pool_full mismatch: expected %b, actual %b",
                   want.pool_full, got.pool_full);
            errors++;
          end
        end
      end
    end
    outstanding <= expected_q.size();
    mismatches <= errors;
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import qbim_pkg::*;

  // generous bound on the whole run, far above the slowest legal schedule
  localparam int CYCLE_LIMIT = 400000;
  // receiver hold-off long enough for the block to back up into its input
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 11;

  typedef enum int {
    PACE_FULL,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [DEPTH_W-1:0] cfg_wdata;
  int                 outstanding;
  int                 mismatches;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_requests = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  int                 cycle_count = 0;
  logic [KEY_W-1:0]   used_keys [$];

  // per phase: depth written, transactions, set share, share of reused keys
  int phase_depth [PHASES] = '{0, 1, 2, 3, 5, 8, 12, 17, 16, 4, 31};
  int phase_items [PHASES] = '{50, 50, 60, 60, 70, 80, 70, 70, 380, 60, 50};
  int phase_sets  [PHASES] = '{50, 50, 50, 50, 50, 50, 50, 50, 85, 50, 60};
  int phase_reuse [PHASES] = '{60, 60, 60, 60, 60, 60, 50, 50, 20, 70, 70};

  qbim_in_if  req_ch ();
  qbim_out_if rsp_ch ();

  quadtree_block_index_map_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  qbim_checker map_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog: a hung handshake or a lost response ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // response side: random stalls, plus a long hold-off whenever the
  // stimulus bumps hold_requests
  always @(posedge clk) begin : rsp_drive
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one request transaction, with random idle cycles in front of it
  task automatic offer(input logic kind, input logic [KEY_W-1:0] key,
                       input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.key       <= key;
    req_ch.new_value <= value;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
  endtask

  // stop offering and let every response drain
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // tree_depth may only change while the block is idle
  task automatic write_depth(input logic [DEPTH_W-1:0] depth);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= depth;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // keys already set at the reuse share (with fresh bits above the used ones), else random
  function automatic logic [KEY_W-1:0] pick_key(input int depth, input int reuse_pct);
    int               levels;
    logic [KEY_W-1:0] span;
    logic [KEY_W-1:0] base;
    levels = (depth > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : depth;
    span = (levels >= 16) ? '1 : ((32'd1 << (2 * levels)) - 32'd1);
    if (used_keys.size() > 0 && $urandom_range(99) < reuse_pct) begin
      base = used_keys[$urandom_range(used_keys.size() - 1)];
      return (base & span) | ($urandom & ~span);
    end
    return $urandom;
  endfunction

  task automatic run_phase(input int p);
    logic             is_set;
    logic [KEY_W-1:0] key;
    int               i;
    case (pace_t'(p % 4))
      PACE_FULL: begin
        idle_pct  <= 0;
        stall_pct <= 0;
      end
      PACE_SEND_IDLE: begin
        idle_pct  <= 80;
        stall_pct <= 0;
      end
      PACE_RECV_STALL: begin
        idle_pct  <= 0;
        stall_pct <= 80;
      end
      default: begin
        idle_pct  <= 21;
        stall_pct <= 21;
      end
    endcase
    write_depth(phase_depth[p]);
    // one phase at full rate gets a long receiver hold-off up front
    if (p == 4) hold_requests <= hold_requests + 1;
    for (i = 0; i < phase_items[p]; i++) begin
      is_set = ($urandom_range(99) < phase_sets[p]);
      key = pick_key(phase_depth[p], phase_reuse[p]);
      offer(is_set ? KIND_SET : KIND_LOOKUP, key, $urandom);
      if (is_set) begin
        used_keys.push_back(key);
        if (used_keys.size() > 64) void'(used_keys.pop_front());
      end
    end
  endtask

  initial begin : stimulus
    int p;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.kind      <= KIND_LOOKUP;
    req_ch.key       <= '0;
    req_ch.new_value <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset depth of 16: empty tree, a full-depth path, shared prefixes
    offer(KIND_LOOKUP, 32'h0000_0000, 32'h0);           // empty root, absent
    offer(KIND_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);   // sixteen new nodes
    offer(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    offer(KIND_LOOKUP, 32'hFFFF_0000, 32'h0);           // misses at the top level
    offer(KIND_SET,    32'h0000_0000, 32'h0000_0000);
    offer(KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);   // new_value ignored
    offer(KIND_SET,    32'hFFFF_FFFF, 32'hA5A5_A5A5);   // complete path, overwrite only
    offer(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    offer(KIND_SET,    32'h8000_8000, 32'h1234_5678);   // reuses the first level
    offer(KIND_LOOKUP, 32'h8000_8000, 32'h0);

    // depth zero: the root is the leaf, key bits are all ignored
    write_depth(5'd0);
    offer(KIND_LOOKUP, 32'h0000_0000, 32'h0);
    offer(KIND_SET,    32'hDEAD_BEEF, 32'h5A5A_5A5A);
    offer(KIND_LOOKUP, 32'h1234_5678, 32'h0);

    // depth above the limit behaves as sixteen levels
    write_depth(5'd31);
    offer(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    offer(KIND_SET,    32'h7FFF_7FFF, 32'hC3C3_C3C3);

    // one level: lands on nodes built for deeper trees, high bits ignored
    write_depth(5'd1);
    offer(KIND_LOOKUP, 32'hFFFF_FFFC, 32'h0);
    offer(KIND_SET,    32'hFFFF_FFF3, 32'h0F0F_0F0F);
    offer(KIND_LOOKUP, 32'h0000_0003, 32'h0);
    offer(KIND_LOOKUP, 32'h0000_0001, 32'h0);           // slot not linked yet
    offer(KIND_SET,    32'hAAAA_AAA1, 32'h0000_0001);
    offer(KIND_LOOKUP, 32'h0000_0001, 32'h0);

    // random phases; the depth-16 phase runs the pool dry
    for (p = 0; p < PHASES; p++) run_phase(p);

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
